// ===== sv/vrq_pkg.sv =====
// Shared constants, types and the axis pick table for the voxel ray occlusion query core.
package vrq_pkg;

    localparam int MAX_SIZE_X_DEF    = 32;
    localparam int MAX_SIZE_Y_DEF    = 32;
    localparam int MAX_SIZE_Z_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int SENSOR_W = 16;
    localparam int SIZE_W   = 6;
    localparam int VOX_W    = 5;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [SENSOR_W-1:0] SENSOR_RESET = 16'd4096;
    localparam logic [SIZE_W-1:0]   SIZE_RESET   = 6'd32;

    localparam logic [1:0] OP_SET   = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [2:0] REG_SENSOR_X = 3'd0;
    localparam logic [2:0] REG_SENSOR_Y = 3'd1;
    localparam logic [2:0] REG_SENSOR_Z = 3'd2;
    localparam logic [2:0] REG_SIZE_X   = 3'd3;
    localparam logic [2:0] REG_SIZE_Y   = 3'd4;
    localparam logic [2:0] REG_SIZE_Z   = 3'd5;

    typedef struct packed {
        logic clear;
        logic mark;
        logic load;
        logic step;
        logic finish;
        logic hit;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic outside;
        logic occupied;
        logic walk_end;
    } t_sts;

    function automatic logic [1:0] axis_pick(input logic [2:0] code);
        logic [1:0] ax;
        case (code)
            3'd0: ax = 2'd2;
            3'd1: ax = 2'd1;
            3'd2: ax = 2'd2;
            3'd3: ax = 2'd1;
            3'd4: ax = 2'd2;
            3'd5: ax = 2'd2;
            3'd6: ax = 2'd0;
            3'd7: ax = 2'd0;
            default: ax = 2'd2;
        endcase
        return ax;
    endfunction

endpackage

// ===== sv/voxel_ray_occlusion_query_core.sv =====
// Top level of the voxel ray occlusion query core: config registers, controller and datapath.
// Mark transaction: no result, busy stays low.
// Query transaction: busy for a map read, then a test and step, per tested voxel; it ends after
// the map read when the start voxel is outside the grid.
// o_valid is high in the cycle after the last busy cycle; no stall.
// After reset the map is cleared one entry per cycle, all MAX_SIZE_X*MAX_SIZE_Y*MAX_SIZE_Z
// entries (32768 by default), with busy high; config writes are taken throughout.
module voxel_ray_occlusion_query_core #(
    parameter int MAX_SIZE_X    = vrq_pkg::MAX_SIZE_X_DEF,
    parameter int MAX_SIZE_Y    = vrq_pkg::MAX_SIZE_Y_DEF,
    parameter int MAX_SIZE_Z    = vrq_pkg::MAX_SIZE_Z_DEF,
    parameter int FRACTION_BITS = vrq_pkg::FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_operation,
    input  logic [vrq_pkg::VOX_W-1:0]         i_voxel_x,
    input  logic [vrq_pkg::VOX_W-1:0]         i_voxel_y,
    input  logic [vrq_pkg::VOX_W-1:0]         i_voxel_z,
    output logic                              o_valid,
    output logic                              o_occluded,
    output logic [vrq_pkg::VOX_W-1:0]         o_hit_x,
    output logic [vrq_pkg::VOX_W-1:0]         o_hit_y,
    output logic [vrq_pkg::VOX_W-1:0]         o_hit_z,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vrq_pkg::PADDR_W-1:0]       paddr,
    input  logic [vrq_pkg::PDATA_W-1:0]       pwdata,
    output logic [vrq_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);

    logic signed [vrq_pkg::SENSOR_W-1:0] r_sensor [3];
    logic [vrq_pkg::SIZE_W-1:0]          r_size [3];
    logic [2:0]                          w_idx;
    logic [vrq_pkg::VOX_W-1:0]           w_voxel [3];
    logic [vrq_pkg::VOX_W-1:0]           w_hit [3];
    vrq_pkg::t_cmd                       w_cmd;
    vrq_pkg::t_sts                       w_sts;

    assign w_idx  = paddr[vrq_pkg::PADDR_W-1:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_sensor[a] <= vrq_pkg::SENSOR_RESET;
                r_size[a]   <= vrq_pkg::SIZE_RESET;
            end
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                vrq_pkg::REG_SENSOR_X: r_sensor[0] <= pwdata[vrq_pkg::SENSOR_W-1:0];
                vrq_pkg::REG_SENSOR_Y: r_sensor[1] <= pwdata[vrq_pkg::SENSOR_W-1:0];
                vrq_pkg::REG_SENSOR_Z: r_sensor[2] <= pwdata[vrq_pkg::SENSOR_W-1:0];
                vrq_pkg::REG_SIZE_X:   r_size[0]   <= pwdata[vrq_pkg::SIZE_W-1:0];
                vrq_pkg::REG_SIZE_Y:   r_size[1]   <= pwdata[vrq_pkg::SIZE_W-1:0];
                vrq_pkg::REG_SIZE_Z:   r_size[2]   <= pwdata[vrq_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            vrq_pkg::REG_SENSOR_X: prdata = vrq_pkg::PDATA_W'(unsigned'(r_sensor[0]));
            vrq_pkg::REG_SENSOR_Y: prdata = vrq_pkg::PDATA_W'(unsigned'(r_sensor[1]));
            vrq_pkg::REG_SENSOR_Z: prdata = vrq_pkg::PDATA_W'(unsigned'(r_sensor[2]));
            vrq_pkg::REG_SIZE_X:   prdata = vrq_pkg::PDATA_W'(r_size[0]);
            vrq_pkg::REG_SIZE_Y:   prdata = vrq_pkg::PDATA_W'(r_size[1]);
            vrq_pkg::REG_SIZE_Z:   prdata = vrq_pkg::PDATA_W'(r_size[2]);
            default:               prdata = '0;
        endcase
    end

    assign w_voxel[0] = i_voxel_x;
    assign w_voxel[1] = i_voxel_y;
    assign w_voxel[2] = i_voxel_z;

    vrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_busy      (busy)
    );

    vrq_datapath #(
        .MAX_SIZE_X    (MAX_SIZE_X),
        .MAX_SIZE_Y    (MAX_SIZE_Y),
        .MAX_SIZE_Z    (MAX_SIZE_Z),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_operation (i_operation),
        .i_voxel     (w_voxel),
        .i_sensor    (r_sensor),
        .i_size      (r_size),
        .o_valid     (o_valid),
        .o_occluded  (o_occluded),
        .o_hit       (w_hit)
    );

    assign o_hit_x = w_hit[0];
    assign o_hit_y = w_hit[1];
    assign o_hit_z = w_hit[2];

endmodule

// ===== sv/vrq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vrq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32768,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/vrq_datapath.sv =====
// Ray walk datapath: occupancy map, ray setup, crossing comparators and result registers.
module vrq_datapath #(
    parameter int MAX_SIZE_X    = vrq_pkg::MAX_SIZE_X_DEF,
    parameter int MAX_SIZE_Y    = vrq_pkg::MAX_SIZE_Y_DEF,
    parameter int MAX_SIZE_Z    = vrq_pkg::MAX_SIZE_Z_DEF,
    parameter int FRACTION_BITS = vrq_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vrq_pkg::t_cmd                       i_cmd,
    output vrq_pkg::t_sts                       o_sts,
    input  logic [1:0]                          i_operation,
    input  logic [vrq_pkg::VOX_W-1:0]           i_voxel [3],
    input  logic signed [vrq_pkg::SENSOR_W-1:0] i_sensor [3],
    input  logic [vrq_pkg::SIZE_W-1:0]          i_size [3],
    output logic                                o_valid,
    output logic                                o_occluded,
    output logic [vrq_pkg::VOX_W-1:0]           o_hit [3]
);

    localparam int DEPTH = MAX_SIZE_X * MAX_SIZE_Y * MAX_SIZE_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAXM  = (MAX_SIZE_X > MAX_SIZE_Y)
                         ? ((MAX_SIZE_X > MAX_SIZE_Z) ? MAX_SIZE_X : MAX_SIZE_Z)
                         : ((MAX_SIZE_Y > MAX_SIZE_Z) ? MAX_SIZE_Y : MAX_SIZE_Z);
    localparam int SW    = $clog2(MAXM + 1);
    localparam int CW    = SW + 1;
    localparam int SPW   = vrq_pkg::VOX_W + FRACTION_BITS;
    localparam int DW    = ((SPW > vrq_pkg::SENSOR_W - 1) ? SPW : vrq_pkg::SENSOR_W - 1) + 2;
    localparam int WALK  = MAX_SIZE_X + MAX_SIZE_Y + MAX_SIZE_Z + 4;
    localparam int IW    = $clog2(WALK);
    localparam int PW    = DW + $clog2(2 * WALK + 2);
    localparam int XW    = ((CW > vrq_pkg::SENSOR_W) ? CW : vrq_pkg::SENSOR_W) + 1;
    localparam int HALF  = 1 << (FRACTION_BITS - 1);
    localparam int MAXV [3] = '{MAX_SIZE_X, MAX_SIZE_Y, MAX_SIZE_Z};
    localparam int PA [6] = '{0, 1, 0, 2, 1, 2};
    localparam int PB [6] = '{1, 0, 2, 0, 2, 1};

    logic signed [CW-1:0] r_pos  [3];
    logic [DW-1:0]        r_dabs [3];
    logic                 r_neg  [3];
    logic signed [XW-1:0] r_endv [3];
    logic [PW-1:0]        r_acc  [6];
    logic [IW-1:0]        r_iter;
    logic [AW-1:0]        r_clr;
    logic                 r_valid;
    logic                 r_occ;
    logic [vrq_pkg::VOX_W-1:0] r_hit [3];

    logic [SW-1:0]        w_size  [3];
    logic signed [DW-1:0] w_d     [3];
    logic [DW-1:0]        w_dabs  [3];
    logic signed [XW-1:0] w_endv  [3];
    logic signed [CW-1:0] w_outv  [3];
    logic signed [CW-1:0] w_npos  [3];
    logic [2:0]           w_code;
    logic [1:0]           w_ax;
    logic                 w_outside;
    logic                 w_at_end;
    logic                 w_at_exit;
    logic                 w_in_range;
    logic [AW-1:0]        w_mark_addr;
    logic [AW-1:0]        w_pos_addr;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic                 w_wdata;
    logic                 w_rdata;

    always_comb begin
        w_outside = 1'b0;
        w_at_end  = 1'b1;
        w_in_range = 1'b1;
        w_code = {r_acc[0] < r_acc[1], r_acc[2] < r_acc[3], r_acc[4] < r_acc[5]};
        w_ax   = vrq_pkg::axis_pick(w_code);
        for (int a = 0; a < 3; a++) begin
            w_size[a] = (int'(i_size[a]) > MAXV[a]) ? SW'(MAXV[a]) : SW'(i_size[a]);
            w_d[a] = DW'(i_sensor[a])
                   - signed'(DW'({i_voxel[a], {FRACTION_BITS{1'b0}}}) + DW'(HALF));
            w_dabs[a] = w_d[a][DW-1] ? DW'(-w_d[a]) : DW'(w_d[a]);
            w_endv[a] = XW'(i_sensor[a] >>> FRACTION_BITS);
            w_outv[a] = r_neg[a] ? CW'(-1) : signed'(CW'(w_size[a]));
            if (r_pos[a] < 0 || r_pos[a] >= signed'(CW'(w_size[a]))) begin
                w_outside = 1'b1;
            end
            if (int'(i_voxel[a]) >= MAXV[a]) begin
                w_in_range = 1'b0;
            end
            if (int'(w_ax) == a) begin
                w_npos[a] = r_neg[a] ? r_pos[a] - CW'(1) : r_pos[a] + CW'(1);
            end else begin
                w_npos[a] = r_pos[a];
            end
            if (XW'(w_npos[a]) != r_endv[a]) begin
                w_at_end = 1'b0;
            end
        end
        w_at_exit = (w_npos[w_ax] == w_outv[w_ax]);
    end

    assign w_mark_addr = AW'((int'(i_voxel[0]) * MAX_SIZE_Y + int'(i_voxel[1])) * MAX_SIZE_Z
                             + int'(i_voxel[2]));
    assign w_pos_addr  = AW'((int'(r_pos[0][CW-2:0]) * MAX_SIZE_Y + int'(r_pos[1][CW-2:0]))
                             * MAX_SIZE_Z + int'(r_pos[2][CW-2:0]));

    assign w_we    = i_cmd.clear | (i_cmd.mark & w_in_range);
    assign w_waddr = i_cmd.clear ? r_clr : w_mark_addr;
    assign w_wdata = ~i_cmd.clear & (i_operation == vrq_pkg::OP_SET);

    vrq_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_pos_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_iter <= '0;
            for (int a = 0; a < 3; a++) begin
                r_pos[a]  <= signed'(CW'(i_voxel[a]));
                r_dabs[a] <= w_dabs[a];
                r_neg[a]  <= w_d[a][DW-1];
                r_endv[a] <= w_endv[a];
            end
            for (int k = 0; k < 6; k++) begin
                r_acc[k] <= PW'(w_dabs[PB[k]]);
            end
        end else if (i_cmd.step) begin
            r_iter <= r_iter + IW'(1);
            r_pos[w_ax] <= w_npos[w_ax];
            for (int k = 0; k < 6; k++) begin
                if (int'(w_ax) == PA[k]) begin
                    r_acc[k] <= r_acc[k] + PW'({r_dabs[PB[k]], 1'b0});
                end
            end
        end
        if (i_cmd.finish) begin
            r_occ <= i_cmd.hit;
            for (int a = 0; a < 3; a++) begin
                r_hit[a] <= i_cmd.hit ? r_pos[a][vrq_pkg::VOX_W-1:0] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.clear) begin
                r_clr <= r_clr + AW'(1);
            end
        end
    end

    assign o_sts.clear_last = (r_clr == AW'(DEPTH - 1));
    assign o_sts.outside    = w_outside;
    assign o_sts.occupied   = w_rdata;
    assign o_sts.walk_end   = w_at_exit | w_at_end | (r_iter == IW'(WALK - 1));

    assign o_valid    = r_valid;
    assign o_occluded = r_occ;
    assign o_hit      = r_hit;

endmodule

// ===== sv/vrq_ctrl.sv =====
// Controller state machine: clearing pass, command intake and ray walk sequencing.
module vrq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_operation,
    input  vrq_pkg::t_sts i_sts,
    output vrq_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_TEST  = 2'd2;
    localparam logic [1:0] S_CHECK = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_operation == vrq_pkg::OP_QUERY) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_TEST;
                    end else if (i_operation == vrq_pkg::OP_SET
                              || i_operation == vrq_pkg::OP_FREE) begin
                        o_cmd.mark = 1'b1;
                    end
                end
            end
            S_TEST: begin
                if (i_sts.outside) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.occupied) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.hit    = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_sts.walk_end) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_TEST;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== sv/vrq_checker.sv =====
// Port-level assertions for the voxel ray occlusion query core, with bind.
module vrq_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [1:0]                i_operation,
    input logic                      o_valid,
    input logic                      o_occluded,
    input logic [vrq_pkg::VOX_W-1:0] o_hit_x,
    input logic [vrq_pkg::VOX_W-1:0] o_hit_y,
    input logic [vrq_pkg::VOX_W-1:0] o_hit_z,
    input logic                      pready
);

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == vrq_pkg::OP_QUERY) |=> busy)
        else $error("query transaction did not raise busy");

    a_mark_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation != vrq_pkg::OP_QUERY) |=> !o_valid)
        else $error("result after a non-query transaction");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_clear_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_occluded) |-> (o_hit_x == '0 && o_hit_y == '0 && o_hit_z == '0))
        else $error("hit coordinates nonzero without occlusion");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind voxel_ray_occlusion_query_core vrq_checker u_vrq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .o_valid     (o_valid),
    .o_occluded  (o_occluded),
    .o_hit_x     (o_hit_x),
    .o_hit_y     (o_hit_y),
    .o_hit_z     (o_hit_z),
    .pready      (pready)
);
